FILE: src/hw2d_pkg.sv
package hw2d_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int TILE        = 8;
  localparam int HALF        = TILE / 2;
  localparam int IDX_BITS    = $clog2(TILE);
  localparam int WORK_BITS   = SAMPLE_BITS + 5;
  localparam int LINE_STAGES = 3;
  localparam int CNT_BITS    = IDX_BITS + 1;

  localparam logic [IDX_BITS-1:0] LAST_ROW  = IDX_BITS'(TILE - 1);
  localparam logic [CNT_BITS-1:0] COLS_LAST = CNT_BITS'(TILE + LINE_STAGES - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [WORK_BITS-1:0]   work_t;
  typedef sample_t [TILE-1:0]            srow_t;
  typedef work_t [TILE-1:0]              line_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROWS,
    ST_COLS,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                ram_wr;
    logic [IDX_BITS-1:0] ram_waddr;
    logic                ram_rd;
    logic [IDX_BITS-1:0] ram_raddr;
    logic                inverse;
    logic                col_issue;
    logic                hshift;
    logic                emit_shift;
  } ctrl_cmd_t;

  typedef struct packed {
    logic line_done;
  } ctrl_status_t;

  function automatic sample_t clamp_sample(work_t v);
    sample_t r;
    if (v > work_t'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else if (v < work_t'(SAMPLE_MIN)) begin
      r = SAMPLE_MIN;
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/hw2d_ram.sv
module hw2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/hw2d_line.sv
module hw2d_line (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                inverse,
  input  hw2d_pkg::line_t     line_in,
  output logic                out_valid,
  output hw2d_pkg::line_t     line_out
);

  // floor mean and its matching difference: a - floor((a+b)/2) == floor((a-b+1)/2)
  function automatic hw2d_pkg::work_t pair_mean(hw2d_pkg::work_t a, hw2d_pkg::work_t b);
    hw2d_pkg::work_t s;
    s = a + b;
    return s >>> 1;
  endfunction

  function automatic hw2d_pkg::work_t pair_diff(hw2d_pkg::work_t a, hw2d_pkg::work_t b);
    hw2d_pkg::work_t d;
    d = a - b + hw2d_pkg::work_t'(1);
    return d >>> 1;
  endfunction

  hw2d_pkg::line_t s1, s2, s3;
  hw2d_pkg::line_t s1_next, s2_next, s3_next;
  logic v1, v2, v3;

  always_comb begin
    s1_next = line_in;
    if (inverse) begin
      s1_next[0] = line_in[0] + line_in[1];
      s1_next[1] = line_in[0] - line_in[1];
    end else begin
      for (int k = 0; k < hw2d_pkg::HALF; k++) begin
        s1_next[k]                  = pair_mean(line_in[2*k], line_in[2*k+1]);
        s1_next[hw2d_pkg::HALF + k] = pair_diff(line_in[2*k], line_in[2*k+1]);
      end
    end
  end

  always_comb begin
    s2_next = s1;
    if (inverse) begin
      s2_next[0] = s1[0] + s1[2];
      s2_next[1] = s1[0] - s1[2];
      s2_next[2] = s1[1] + s1[3];
      s2_next[3] = s1[1] - s1[3];
    end else begin
      s2_next[0] = pair_mean(s1[0], s1[1]);
      s2_next[1] = pair_mean(s1[2], s1[3]);
      s2_next[2] = pair_diff(s1[0], s1[1]);
      s2_next[3] = pair_diff(s1[2], s1[3]);
    end
  end

  always_comb begin
    s3_next = s2;
    if (inverse) begin
      for (int k = 0; k < hw2d_pkg::HALF; k++) begin
        s3_next[2*k]   = s2[k] + s2[hw2d_pkg::HALF + k];
        s3_next[2*k+1] = s2[k] - s2[hw2d_pkg::HALF + k];
      end
    end else begin
      s3_next[0] = pair_mean(s2[0], s2[1]);
      s3_next[1] = pair_diff(s2[0], s2[1]);
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    s2 <= s2_next;
    s3 <= s3_next;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;
  assign line_out  = s3;

endmodule

FILE: src/hw2d_datapath.sv
module hw2d_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  hw2d_pkg::ctrl_cmd_t    cmd,
  output hw2d_pkg::ctrl_status_t status,
  input  hw2d_pkg::srow_t        row_in,
  output hw2d_pkg::srow_t        coefs
);

  hw2d_pkg::srow_t rd_row;
  logic            rd_valid;
  hw2d_pkg::line_t line_in;
  hw2d_pkg::line_t line_out;
  logic            line_valid;
  hw2d_pkg::work_t tile [hw2d_pkg::TILE][hw2d_pkg::TILE];

  hw2d_ram #(
    .WIDTH (hw2d_pkg::TILE * hw2d_pkg::SAMPLE_BITS),
    .DEPTH (hw2d_pkg::TILE)
  ) u_store (
    .clk   (clk),
    .we    (cmd.ram_wr),
    .waddr (cmd.ram_waddr),
    .wdata (row_in),
    .re    (cmd.ram_rd),
    .raddr (cmd.ram_raddr),
    .rdata (rd_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.ram_rd;
    end
  end

  // row pass feeds stored rows, column pass feeds the left column of the turn buffer
  always_comb begin
    for (int i = 0; i < hw2d_pkg::TILE; i++) begin
      line_in[i] = cmd.col_issue ? tile[i][0] : hw2d_pkg::work_t'(rd_row[i]);
    end
  end

  hw2d_line u_line (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid || cmd.col_issue),
    .inverse   (cmd.inverse),
    .line_in   (line_in),
    .out_valid (line_valid),
    .line_out  (line_out)
  );

  assign status.line_done = line_valid;

  // corner turn: rows enter from the bottom, columns enter from the right
  always_ff @(posedge clk) begin
    priority if (cmd.hshift) begin
      for (int r = 0; r < hw2d_pkg::TILE; r++) begin
        for (int c = 0; c < hw2d_pkg::TILE - 1; c++) begin
          tile[r][c] <= tile[r][c+1];
        end
        tile[r][hw2d_pkg::TILE-1] <= line_out[r];
      end
    end else if (line_valid) begin
      for (int r = 0; r < hw2d_pkg::TILE - 1; r++) begin
        tile[r] <= tile[r+1];
      end
      for (int c = 0; c < hw2d_pkg::TILE; c++) begin
        tile[hw2d_pkg::TILE-1][c] <= line_out[c];
      end
    end else if (cmd.emit_shift) begin
      for (int r = 0; r < hw2d_pkg::TILE - 1; r++) begin
        tile[r] <= tile[r+1];
      end
    end else begin
    end
  end

  always_comb begin
    for (int c = 0; c < hw2d_pkg::TILE; c++) begin
      coefs[c] = hw2d_pkg::clamp_sample(tile[0][c]);
    end
  end

  a_no_store_write_in_pass: assert property (@(posedge clk) disable iff (rst)
    (cmd.ram_rd || rd_valid || line_valid) |-> !cmd.ram_wr)
    else $error("tile store written while a pass reads it");

endmodule

FILE: src/hw2d_ctrl.sv
module hw2d_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_data,
  output logic [hw2d_pkg::IDX_BITS-1:0]       row_number,
  output logic                                last_row,
  output hw2d_pkg::ctrl_cmd_t                 cmd,
  input  hw2d_pkg::ctrl_status_t              status
);

  hw2d_pkg::state_t state, state_next;
  logic [hw2d_pkg::CNT_BITS-1:0] cnt, cnt_next;
  logic [hw2d_pkg::IDX_BITS-1:0] res, res_next;
  logic [hw2d_pkg::IDX_BITS-1:0] rows, rows_next;
  logic direction, direction_next;
  logic mode, mode_next;
  logic in_xfer, out_xfer, cfg_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      hw2d_pkg::ST_LOAD: begin
        if (in_xfer && rows == hw2d_pkg::LAST_ROW) state_next = hw2d_pkg::ST_ROWS;
      end
      hw2d_pkg::ST_ROWS: begin
        if (status.line_done && res == hw2d_pkg::LAST_ROW) state_next = hw2d_pkg::ST_COLS;
      end
      hw2d_pkg::ST_COLS: begin
        if (cnt == hw2d_pkg::COLS_LAST) state_next = hw2d_pkg::ST_EMIT;
      end
      hw2d_pkg::ST_EMIT: begin
        if (out_xfer && cnt[hw2d_pkg::IDX_BITS-1:0] == hw2d_pkg::LAST_ROW) begin
          state_next = hw2d_pkg::ST_LOAD;
        end
      end
      default: state_next = hw2d_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cfg_ready      = 1'b1;
    cmd.ram_rd     = 1'b0;
    cmd.col_issue  = 1'b0;
    cmd.hshift     = 1'b0;
    unique case (state)
      hw2d_pkg::ST_LOAD: in_ready = 1'b1;
      hw2d_pkg::ST_ROWS: cmd.ram_rd = !cnt[hw2d_pkg::IDX_BITS];
      hw2d_pkg::ST_COLS: begin
        cmd.hshift    = 1'b1;
        cmd.col_issue = !cnt[hw2d_pkg::IDX_BITS];
      end
      hw2d_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        in_ready  = (rows != hw2d_pkg::LAST_ROW);
      end
      default: ;
    endcase
    cmd.ram_wr     = in_xfer;
    cmd.ram_waddr  = rows;
    cmd.ram_raddr  = cnt[hw2d_pkg::IDX_BITS-1:0];
    cmd.inverse    = mode;
    cmd.emit_shift = out_xfer;
    row_number     = cnt[hw2d_pkg::IDX_BITS-1:0];
    last_row       = (cnt[hw2d_pkg::IDX_BITS-1:0] == hw2d_pkg::LAST_ROW);
  end

  always_comb begin
    rows_next      = in_xfer ? rows + 1'b1 : rows;
    direction_next = cfg_xfer ? cfg_data : direction;
    mode_next      = (in_xfer && rows == hw2d_pkg::LAST_ROW) ? direction : mode;
    res_next       = (state == hw2d_pkg::ST_ROWS && status.line_done) ? res + 1'b1 : res;
    unique case (state)
      hw2d_pkg::ST_ROWS: cnt_next = cnt[hw2d_pkg::IDX_BITS] ? cnt : cnt + 1'b1;
      hw2d_pkg::ST_COLS: cnt_next = cnt + 1'b1;
      hw2d_pkg::ST_EMIT: cnt_next = out_xfer ? cnt + 1'b1 : cnt;
      default:           cnt_next = '0;
    endcase
    if (state_next != state) cnt_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hw2d_pkg::ST_LOAD;
      cnt       <= '0;
      res       <= '0;
      rows      <= '0;
      direction <= 1'b0;
      mode      <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      res       <= res_next;
      rows      <= rows_next;
      direction <= direction_next;
      mode      <= mode_next;
    end
  end

  a_tile_full_starts_pass: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && rows == hw2d_pkg::LAST_ROW) |=> (state == hw2d_pkg::ST_ROWS))
    else $error("full tile did not start the row pass");

  a_results_only_in_pass: assert property (@(posedge clk) disable iff (rst)
    status.line_done |-> (state == hw2d_pkg::ST_ROWS || state == hw2d_pkg::ST_COLS))
    else $error("line result outside a pass");

  a_no_input_in_pass: assert property (@(posedge clk) disable iff (rst)
    (state == hw2d_pkg::ST_ROWS || state == hw2d_pkg::ST_COLS) |-> !in_ready)
    else $error("input taken during a pass");

  a_emit_in_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=>
      (out_valid && row_number == hw2d_pkg::IDX_BITS'($past(row_number) + 1'b1)))
    else $error("result rows out of order");

endmodule

FILE: src/haar_2d_tile_transform_top.sv
// Three-level 2D Haar mean/difference transform on 8x8 tiles (direction 0 forward,
// 1 inverse, sampled with the eighth row). Eight row transfers fill the tile store;
// a shared three-stage line unit then runs a row pass (store read plus pipeline)
// and a column pass through a register corner turn, after which the eight result
// rows leave one per cycle while out_ready is high, with row_number and last_row.
// Rows 0..6 of the next tile are taken while results drain, so with both sides
// ready the tile rate is set by the single line unit serving both passes. Outputs
// saturate to the sample range.
module haar_2d_tile_transform_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  hw2d_pkg::sample_t                     sample_0,
  input  hw2d_pkg::sample_t                     sample_1,
  input  hw2d_pkg::sample_t                     sample_2,
  input  hw2d_pkg::sample_t                     sample_3,
  input  hw2d_pkg::sample_t                     sample_4,
  input  hw2d_pkg::sample_t                     sample_5,
  input  hw2d_pkg::sample_t                     sample_6,
  input  hw2d_pkg::sample_t                     sample_7,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output hw2d_pkg::sample_t                     coef_0,
  output hw2d_pkg::sample_t                     coef_1,
  output hw2d_pkg::sample_t                     coef_2,
  output hw2d_pkg::sample_t                     coef_3,
  output hw2d_pkg::sample_t                     coef_4,
  output hw2d_pkg::sample_t                     coef_5,
  output hw2d_pkg::sample_t                     coef_6,
  output hw2d_pkg::sample_t                     coef_7,
  output logic [hw2d_pkg::IDX_BITS-1:0]         row_number,
  output logic                                  last_row
);

  hw2d_pkg::ctrl_cmd_t    cmd;
  hw2d_pkg::ctrl_status_t status;
  hw2d_pkg::srow_t        row_in;
  hw2d_pkg::srow_t        coefs;

  assign row_in[0] = sample_0;
  assign row_in[1] = sample_1;
  assign row_in[2] = sample_2;
  assign row_in[3] = sample_3;
  assign row_in[4] = sample_4;
  assign row_in[5] = sample_5;
  assign row_in[6] = sample_6;
  assign row_in[7] = sample_7;

  assign coef_0 = coefs[0];
  assign coef_1 = coefs[1];
  assign coef_2 = coefs[2];
  assign coef_3 = coefs[3];
  assign coef_4 = coefs[4];
  assign coef_5 = coefs[5];
  assign coef_6 = coefs[6];
  assign coef_7 = coefs[7];

  hw2d_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .row_number (row_number),
    .last_row   (last_row),
    .cmd        (cmd),
    .status     (status)
  );

  hw2d_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .row_in (row_in),
    .coefs  (coefs)
  );

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import hw2d_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_TILES  = 40;

  typedef struct packed {
    srow_t               coef;
    logic [IDX_BITS-1:0] row;
    logic                last;
  } coef_row_t;

  class haar_tile_scoreboard;
    longint    tile[TILE][TILE];
    longint    work[TILE][TILE];
    int        rows_held;
    bit        inverse;
    int        errors;
    coef_row_t expected_rows[$];

    function void set_direction(bit d);
      inverse = d;
    endfunction

    function sample_t saturate(longint v);
      sample_t s;
      if (v > longint'(SAMPLE_MAX)) begin
        s = SAMPLE_MAX;
      end else if (v < longint'(SAMPLE_MIN)) begin
        s = SAMPLE_MIN;
      end else begin
        s = sample_t'(v);
      end
      return s;
    endfunction

    function void mean_diff_line(int k, bit down);
      longint a[TILE];
      longint r[TILE];
      longint b0, b1, b2, b3, c0, c1, d0;
      for (int i = 0; i < TILE; i++) a[i] = down ? work[i][k] : work[k][i];
      b0 = (a[0] + a[1]) >>> 1;
      b1 = (a[2] + a[3]) >>> 1;
      b2 = (a[4] + a[5]) >>> 1;
      b3 = (a[6] + a[7]) >>> 1;
      r[4] = a[0] - b0;
      r[5] = a[2] - b1;
      r[6] = a[4] - b2;
      r[7] = a[6] - b3;
      c0 = (b0 + b1) >>> 1;
      c1 = (b2 + b3) >>> 1;
      r[2] = b0 - c0;
      r[3] = b2 - c1;
      d0 = (c0 + c1) >>> 1;
      r[0] = d0;
      r[1] = c0 - d0;
      for (int i = 0; i < TILE; i++) begin
        if (down) begin
          work[i][k] = r[i];
        end else begin
          work[k][i] = r[i];
        end
      end
    endfunction

    function void rebuild_line(int k, bit down);
      longint p[TILE];
      longint r[TILE];
      longint b0, b1, c0, c1, c2, c3;
      for (int i = 0; i < TILE; i++) p[i] = down ? work[i][k] : work[k][i];
      b0 = p[0] + p[1];
      b1 = p[0] - p[1];
      c0 = b0 + p[2];
      c1 = b0 - p[2];
      c2 = b1 + p[3];
      c3 = b1 - p[3];
      r[0] = c0 + p[4];
      r[1] = c0 - p[4];
      r[2] = c1 + p[5];
      r[3] = c1 - p[5];
      r[4] = c2 + p[6];
      r[5] = c2 - p[6];
      r[6] = c3 + p[7];
      r[7] = c3 - p[7];
      for (int i = 0; i < TILE; i++) begin
        if (down) begin
          work[i][k] = r[i];
        end else begin
          work[k][i] = r[i];
        end
      end
    endfunction

    function void note_row(srow_t r);
      coef_row_t e;
      for (int i = 0; i < TILE; i++) tile[rows_held][i] = longint'($signed(r[i]));
      if (rows_held != TILE - 1) begin
        rows_held++;
        return;
      end
      rows_held = 0;
      work = tile;
      if (!inverse) begin
        for (int k = 0; k < TILE; k++) mean_diff_line(k, 1'b0);
        for (int k = 0; k < TILE; k++) mean_diff_line(k, 1'b1);
      end else begin
        for (int k = 0; k < TILE; k++) rebuild_line(k, 1'b1);
        for (int k = 0; k < TILE; k++) rebuild_line(k, 1'b0);
      end
      for (int k = 0; k < TILE; k++) begin
        for (int i = 0; i < TILE; i++) e.coef[i] = saturate(work[k][i]);
        e.row  = IDX_BITS'(k);
        e.last = (k == TILE - 1);
        expected_rows.push_back(e);
      end
    endfunction

    function void check_row(coef_row_t got);
      coef_row_t want;
      if (expected_rows.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row %0d", $time, got.row);
        return;
      end
      want = expected_rows.pop_front();
      for (int i = 0; i < TILE; i++) begin
        if (got.coef[i] !== want.coef[i]) begin
          errors++;
          $display("%0t: row %0d coef_%0d expected %0d actual %0d", $time, want.row, i,
                   $signed(want.coef[i]), $signed(got.coef[i]));
        end
      end
      if (got.row !== want.row) begin
        errors++;
        $display("%0t: row_number expected %0d actual %0d", $time, want.row, got.row);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: row %0d last_row expected %0b actual %0b", $time, want.row,
                 want.last, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid;
  logic cfg_data;
  logic in_valid;
  srow_t in_row;
  logic out_ready;
  wire cfg_ready;
  wire in_ready;
  wire out_valid;
  wire srow_t out_row;
  wire [IDX_BITS-1:0] row_number;
  wire last_row;

  int cycles = 0;
  bit send_fast;
  bit take_fast;
  haar_tile_scoreboard sb = new();

  haar_2d_tile_transform_top DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_0   (in_row[0]),
    .sample_1   (in_row[1]),
    .sample_2   (in_row[2]),
    .sample_3   (in_row[3]),
    .sample_4   (in_row[4]),
    .sample_5   (in_row[5]),
    .sample_6   (in_row[6]),
    .sample_7   (in_row[7]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .coef_0     (out_row[0]),
    .coef_1     (out_row[1]),
    .coef_2     (out_row[2]),
    .coef_3     (out_row[3]),
    .coef_4     (out_row[4]),
    .coef_5     (out_row[5]),
    .coef_6     (out_row[6]),
    .coef_7     (out_row[7]),
    .row_number (row_number),
    .last_row   (last_row)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) sb.set_direction(cfg_data);
    if (!rst && in_valid && in_ready) sb.note_row(in_row);
    if (!rst && out_valid && out_ready) sb.check_row({out_row, row_number, last_row});
  end

  function automatic srow_t random_row(int kind);
    srow_t r;
    for (int i = 0; i < TILE; i++) begin
      case (kind)
        0: r[i] = sample_t'($urandom);
        1: r[i] = sample_t'(int'($urandom_range(0, 400)) - 200);
        default: begin
          case ($urandom_range(0, 4))
            0: r[i] = SAMPLE_MAX;
            1: r[i] = SAMPLE_MIN;
            2: r[i] = '0;
            3: r[i] = sample_t'(1);
            default: r[i] = sample_t'(-1);
          endcase
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_row(input srow_t r);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row <= r;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Hold off input until every expected row is out, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(input bit d);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 15) == 0) take_fast = !take_fast;
      stall = take_fast ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    srow_t r;
    int cut;
    int kind;
    cfg_valid <= 1'b0;
    cfg_data <= 1'b0;
    in_valid <= 1'b0;
    in_row <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_direction(1'b0);
    // forward on a full-scale checkerboard
    for (int k = 0; k < TILE; k++) begin
      for (int i = 0; i < TILE; i++) r[i] = ((k + i) % 2 == 0) ? SAMPLE_MAX : SAMPLE_MIN;
      send_row(r);
    end
    write_direction(1'b1);
    // inverse on full-scale rows, outputs saturate both ways
    for (int k = 0; k < TILE; k++) begin
      for (int i = 0; i < TILE; i++) r[i] = (k < HALF) ? SAMPLE_MAX : SAMPLE_MIN;
      send_row(r);
    end
    // direction flips mid-tile; the setting at the last row applies
    for (int k = 0; k < TILE; k++) begin
      if (k == HALF) write_direction(1'b0);
      send_row(random_row(2));
    end

    for (int t = 0; t < RANDOM_TILES; t++) begin
      send_fast = ($urandom_range(0, 3) == 0);
      if (t % 7 == 6) write_direction(1'($urandom_range(0, 1)));
      cut = (t % 5 == 4) ? $urandom_range(1, TILE - 1) : TILE;
      for (int k = 0; k < TILE; k++) begin
        if (k == cut) write_direction(1'($urandom_range(0, 1)));
        kind = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
        send_row(random_row(kind));
      end
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
src/hw2d_pkg.sv
src/hw2d_ram.sv
src/hw2d_line.sv
src/hw2d_datapath.sv
src/hw2d_ctrl.sv
src/haar_2d_tile_transform_top.sv
test/tb.sv
